// ===== src/spi_ars_pkg.sv =====
// Shared types and constants for the SPI ADC read sequencer.
`timescale 1ns / 1ps

package spi_ars_pkg;

  // Frame layout of one ADC transaction, in serial bit periods
  localparam int COMMAND_BITS  = 8;
  localparam int WAIT_CLOCKS   = 5;
  localparam int SAMPLE_BITS   = 12;
  localparam int TOTAL_PERIODS = COMMAND_BITS + WAIT_CLOCKS + SAMPLE_BITS;
  localparam int PERIOD_W      = $clog2(TOTAL_PERIODS);
  localparam int BYTE_W        = 8;

  typedef logic [PERIOD_W-1:0]     period_t;
  typedef logic [COMMAND_BITS-1:0] command_t;
  typedef logic [SAMPLE_BITS-1:0]  reading_t;

  // Period boundaries at counter width
  localparam period_t CMD_END  = period_t'(COMMAND_BITS);
  localparam period_t WAIT_END = period_t'(COMMAND_BITS + WAIT_CLOCKS);
  localparam period_t LAST_PER = period_t'(TOTAL_PERIODS - 1);

  // Item kind carried on tuser
  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_PERIOD = 1'b1
  } action_t;

  // One input item
  typedef struct packed {
    action_t            action;
    logic [BYTE_W-1:0]  control_byte;
    logic               select_current;
    logic               two_byte;
    logic               miso;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic               mosi;
    logic               sclk_pulse;
    logic               cs_voltage_n;
    logic               cs_current_n;
    logic               busy_res;
    logic               done_res;
    logic               rejected;
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  second_byte;
  } res_t;

endpackage

// ===== src/spi_ars_core.sv =====
// Sequencer state and per-item step logic of the SPI ADC read sequencer.
`timescale 1ns / 1ps

module spi_ars_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  spi_ars_pkg::in_item_t item,
  output spi_ars_pkg::res_t     res
);

  spi_ars_pkg::period_t  period_count, period_count_next;
  spi_ars_pkg::command_t command_shift, command_shift_next;
  spi_ars_pkg::reading_t reading_shift, reading_shift_next;
  logic                  active, active_next;
  logic                  chosen_adc, chosen_adc_next;
  logic                  wide_result, wide_result_next;

  // Step logic: next state and result for the item on the input
  always_comb begin
    period_count_next  = period_count;
    command_shift_next = command_shift;
    reading_shift_next = reading_shift;
    active_next        = active;
    chosen_adc_next    = chosen_adc;
    wide_result_next   = wide_result;

    res             = '0;
    res.mosi        = 1'b1;

    if (item.action == spi_ars_pkg::ACT_START) begin
      if (active) begin
        res.rejected = 1'b1;
      end else begin
        command_shift_next = item.control_byte;
        chosen_adc_next    = item.select_current;
        wide_result_next   = item.two_byte;
        reading_shift_next = '0;
        period_count_next  = '0;
        active_next        = 1'b1;
      end
    end else if (!active) begin
      res.rejected = 1'b1;
    end else begin
      res.sclk_pulse = 1'b1;
      if (period_count < spi_ars_pkg::CMD_END) begin
        // command phase: MSB first
        res.mosi           = command_shift[spi_ars_pkg::COMMAND_BITS-1];
        command_shift_next = {command_shift[spi_ars_pkg::COMMAND_BITS-2:0], 1'b0};
      end else if (period_count < spi_ars_pkg::WAIT_END) begin
        res.mosi = 1'b0;
      end else begin
        // sample phase: MISO shifts in MSB first
        res.mosi           = 1'b0;
        reading_shift_next = {reading_shift[spi_ars_pkg::SAMPLE_BITS-2:0], item.miso};
      end

      if (period_count == spi_ars_pkg::LAST_PER) begin
        active_next       = 1'b0;
        period_count_next = '0;
        res.done_res      = 1'b1;
        if (wide_result) begin
          res.first_byte  = spi_ars_pkg::BYTE_W'(reading_shift_next >> spi_ars_pkg::BYTE_W);
          res.second_byte = reading_shift_next[spi_ars_pkg::BYTE_W-1:0];
        end else begin
          res.first_byte  =
            reading_shift_next[spi_ars_pkg::SAMPLE_BITS-1 -: spi_ars_pkg::BYTE_W];
        end
      end else begin
        period_count_next = spi_ars_pkg::period_t'(period_count + 1'b1);
      end
    end

    // chip selects follow the state after this item
    res.cs_voltage_n = !(active_next && !chosen_adc_next);
    res.cs_current_n = !(active_next && chosen_adc_next);
    res.busy_res     = active_next;
  end

  // State registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count  <= '0;
      command_shift <= '0;
      reading_shift <= '0;
      active        <= 1'b0;
      chosen_adc    <= 1'b0;
      wide_result   <= 1'b0;
    end else if (accept) begin
      period_count  <= period_count_next;
      command_shift <= command_shift_next;
      reading_shift <= reading_shift_next;
      active        <= active_next;
      chosen_adc    <= chosen_adc_next;
      wide_result   <= wide_result_next;
    end
  end

endmodule

// ===== src/spi_adc_read_sequencer.sv =====
// Top level of the SPI ADC read sequencer: stream ports and result register.
`timescale 1ns / 1ps

// Bit-level SPI master for two serial 12-bit ADCs. A start item (tuser 0) while
// idle latches the control byte, the ADC select and the result size and drops the
// chosen chip select; each bit-period item (tuser 1) in a frame is one SCLK pulse:
// 8 command bits out on MOSI MSB first, 5 wait clocks, then 12 MISO samples.
// Other items are rejected. The item with the last sample carries the reading and
// tlast. Every input item gives exactly one result item. One item is taken per
// clock; the result appears on the master side in the cycle after its transfer,
// out of a single result register, and a stall on the master side holds the slave
// side only while that register is full and not being taken.

module spi_adc_read_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] control_byte, [8] select_current, [9] two_byte, [10] miso
  input  logic [15:0] s_tdata,
  // [0] action
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] mosi, [1] sclk_pulse, [2] cs_voltage_n, [3] cs_current_n,
  // [4] busy_res, [5] rejected, [13:6] first_byte, [21:14] second_byte
  output logic [23:0] m_tdata,
  // done_res
  output logic        m_tlast
);

  spi_ars_pkg::in_item_t item;
  spi_ars_pkg::res_t     step_res;
  spi_ars_pkg::res_t     out_res;
  logic                  s_xfer;

  // Input unpacking
  always_comb begin
    item.action         = spi_ars_pkg::action_t'(s_tuser);
    item.control_byte   = s_tdata[7:0];
    item.select_current = s_tdata[8];
    item.two_byte       = s_tdata[9];
    item.miso           = s_tdata[10];
  end

  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;

  spi_ars_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (s_xfer),
    .item   (item),
    .res    (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      out_res <= step_res;
    end
  end

  // Output packing
  assign m_tdata = {2'b00, out_res.second_byte, out_res.first_byte, out_res.rejected,
                    out_res.busy_res, out_res.cs_current_n, out_res.cs_voltage_n,
                    out_res.sclk_pulse, out_res.mosi};
  assign m_tlast = out_res.done_res;

  // Checks
  a_one_cs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.cs_voltage_n || out_res.cs_current_n))
    else $error("both chip selects active");

  a_busy_cs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.busy_res == !(out_res.cs_voltage_n && out_res.cs_current_n)))
    else $error("busy does not match chip selects");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.done_res) |-> (!out_res.busy_res && out_res.sclk_pulse))
    else $error("done without final clock or still busy");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.rejected) |-> (!out_res.sclk_pulse && out_res.mosi))
    else $error("rejected item drove the serial bus");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && s_tuser == spi_ars_pkg::ACT_START) |=> out_res.busy_res)
    else $error("start left the sequencer idle");

endmodule

// ===== tb/sv/tb_spi_adc_read_sequencer.sv =====
// Self-checking testbench for the SPI ADC read sequencer: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_spi_adc_read_sequencer;

  localparam int RANDOM_ITEMS = 850;
  localparam int SHOW_LIMIT   = 10;

  // Predicts one result item per accepted item and checks the result stream
  class adc_frame_scoreboard;
    spi_ars_pkg::period_t  periods_done;
    spi_ars_pkg::command_t cmd_bits;
    spi_ars_pkg::reading_t sample_bits;
    bit                    in_frame;
    bit                    use_current;
    bit                    wide;
    spi_ars_pkg::res_t     expected_q[$];
    int                    failures;

    function void clear_state();
      periods_done = '0;
      cmd_bits     = '0;
      sample_bits  = '0;
      in_frame     = 1'b0;
      use_current  = 1'b0;
      wide         = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= SHOW_LIMIT) $display("%0t ns: %s", $time, msg);
    endfunction

    function void compare(string what, logic [7:0] want_v, logic [7:0] seen_v);
      if (want_v !== seen_v)
        note_failure($sformatf("%s mismatch: expected %0h, got %0h", what, want_v, seen_v));
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_input(spi_ars_pkg::in_item_t item);
      spi_ars_pkg::res_t r;
      r = '0;
      r.mosi = 1'b1;
      if (item.action == spi_ars_pkg::ACT_START) begin
        if (in_frame) begin
          r.rejected = 1'b1;
        end else begin
          cmd_bits     = item.control_byte;
          use_current  = item.select_current;
          wide         = item.two_byte;
          sample_bits  = '0;
          periods_done = '0;
          in_frame     = 1'b1;
        end
      end else if (!in_frame) begin
        r.rejected = 1'b1;
      end else begin
        r.sclk_pulse = 1'b1;
        if (periods_done < spi_ars_pkg::CMD_END) begin
          r.mosi   = cmd_bits[spi_ars_pkg::COMMAND_BITS-1];
          cmd_bits = cmd_bits << 1;
        end else if (periods_done < spi_ars_pkg::WAIT_END) begin
          r.mosi = 1'b0;
        end else begin
          r.mosi      = 1'b0;
          sample_bits = {sample_bits[spi_ars_pkg::SAMPLE_BITS-2:0], item.miso};
        end
        if (periods_done == spi_ars_pkg::LAST_PER) begin
          in_frame     = 1'b0;
          periods_done = '0;
          r.done_res   = 1'b1;
          if (wide) begin
            r.first_byte  = spi_ars_pkg::BYTE_W'(sample_bits >> spi_ars_pkg::BYTE_W);
            r.second_byte = sample_bits[spi_ars_pkg::BYTE_W-1:0];
          end else begin
            r.first_byte  = spi_ars_pkg::BYTE_W'(sample_bits >>
                              (spi_ars_pkg::SAMPLE_BITS - spi_ars_pkg::BYTE_W));
          end
        end else begin
          periods_done = periods_done + 1'b1;
        end
      end
      r.cs_voltage_n = !(in_frame && !use_current);
      r.cs_current_n = !(in_frame && use_current);
      r.busy_res     = in_frame;
      expected_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [23:0] data, logic last);
      spi_ars_pkg::res_t want;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("result %h with nothing expected", data));
        return;
      end
      want = expected_q.pop_front();
      compare("mosi", 8'(want.mosi), 8'(data[0]));
      compare("sclk_pulse", 8'(want.sclk_pulse), 8'(data[1]));
      compare("cs_voltage_n", 8'(want.cs_voltage_n), 8'(data[2]));
      compare("cs_current_n", 8'(want.cs_current_n), 8'(data[3]));
      compare("busy_res", 8'(want.busy_res), 8'(data[4]));
      compare("rejected", 8'(want.rejected), 8'(data[5]));
      compare("first_byte", want.first_byte, data[13:6]);
      compare("second_byte", want.second_byte, data[21:14]);
      compare("tdata padding", 8'h00, 8'(data[23:22]));
      compare("done_res", 8'(want.done_res), 8'(last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  adc_frame_scoreboard sb;
  int items_sent;
  bit steady;

  spi_adc_read_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic spi_ars_pkg::in_item_t rand_item(spi_ars_pkg::action_t act);
    spi_ars_pkg::in_item_t item;
    item.action         = act;
    item.control_byte   = 8'($urandom_range(0, 255));
    item.select_current = 1'($urandom_range(0, 1));
    item.two_byte       = 1'($urandom_range(0, 1));
    item.miso           = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // Drive one item and wait for its transfer; starts and ends at a falling edge
  task automatic send_item(spi_ars_pkg::in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = item.action;
    s_tdata  = {5'b0, item.miso, item.two_byte, item.select_current, item.control_byte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(item);
    items_sent++;
    @(negedge clk);
  endtask

  // One full frame with random content, sometimes with a start during the frame
  task automatic run_frame();
    int k;
    steady = ($urandom_range(0, 3) == 0);
    send_item(rand_item(spi_ars_pkg::ACT_START));
    for (k = 0; k < spi_ars_pkg::TOTAL_PERIODS; k++) begin
      if ($urandom_range(0, 99) < 5) send_item(rand_item(spi_ars_pkg::ACT_START));
      send_item(rand_item(spi_ars_pkg::ACT_PERIOD));
    end
  endtask

  // Result side: random stalls, checked at the rising edge
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_tready = 1'b0;
          stall_left = g - 1;
        end else begin
          m_tready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // Stimulus and end of run
  initial begin
    spi_ars_pkg::in_item_t item;
    int k;
    sb = new();
    sb.clear_state();
    items_sent = 0;
    steady = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = spi_ars_pkg::ACT_START;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: bit period while idle, start, start while busy, all-ones frame
    item = '{action: spi_ars_pkg::ACT_PERIOD, control_byte: 8'h00, select_current: 1'b0,
             two_byte: 1'b0, miso: 1'b1};
    send_item(item);
    item = '{action: spi_ars_pkg::ACT_START, control_byte: 8'hFF, select_current: 1'b0,
             two_byte: 1'b1, miso: 1'b0};
    send_item(item);
    item = '{action: spi_ars_pkg::ACT_START, control_byte: 8'h00, select_current: 1'b1,
             two_byte: 1'b0, miso: 1'b1};
    send_item(item);
    for (k = 0; k < spi_ars_pkg::TOTAL_PERIODS; k++) begin
      item = '{action: spi_ars_pkg::ACT_PERIOD, control_byte: 8'h00, select_current: 1'b1,
               two_byte: 1'b0, miso: 1'b1};
      send_item(item);
    end

    // Random: mostly whole frames, some stray bit periods while idle
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 10) send_item(rand_item(spi_ars_pkg::ACT_PERIOD));
      else run_frame();
    end
    s_tvalid = 1'b0;

    // Drain, then keep watching to catch stray results
    steady = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS spi_adc_read_sequencer");
    end else begin
      $display("FAIL spi_adc_read_sequencer");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("FAIL spi_adc_read_sequencer");
    $finish;
  end

endmodule

// ===== files.f =====
src/spi_ars_pkg.sv
src/spi_ars_core.sv
src/spi_adc_read_sequencer.sv
tb/sv/tb_spi_adc_read_sequencer.sv
